// ===== hdl/mppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mppt_pkg;

  // Sample and accumulator widths.
  localparam int SAMPLE_BITS  = 10;
  localparam int MAX_AVERAGE  = 128;
  localparam int AVG_LOG2_MAX = $clog2(MAX_AVERAGE);
  localparam int AVG_LOG2_W   = 3;
  localparam int SUM_W        = SAMPLE_BITS + AVG_LOG2_MAX;
  localparam int IDX_W        = AVG_LOG2_MAX + 1;

  // Result widths.
  localparam int DUTY_W   = 8;
  localparam int POWER_W  = 20;
  localparam int WAIT_W   = 16;
  localparam int STREAK_W = 8;
  localparam int STEP_W   = DUTY_W + STREAK_W;
  localparam int VALUE_W  = STEP_W + 2;

  // Streak limits; the wait is divided by the streak above STREAK_FAST.
  localparam int STREAK_LIMIT = 255;
  localparam int STREAK_FAST  = 3;

  // Serial multiplier: operands as wide as an averaged sum.
  localparam int OPND_W     = SUM_W;
  localparam int MUL_CNT_W  = $clog2(OPND_W);
  localparam int PROD_W     = 2 * OPND_W;

  // Serial divider: wait base divided by the streak.
  localparam int DIV_CNT_W = $clog2(WAIT_W);

  // Register reset values.
  localparam logic [DUTY_W-1:0]     DUTY_MAX_RST  = DUTY_W'(255);
  localparam logic [DUTY_W-1:0]     DUTY_MIN_RST  = DUTY_W'(0);
  localparam logic [DUTY_W-1:0]     DUTY_STEP_RST = DUTY_W'(1);
  localparam logic [WAIT_W-1:0]     WAIT_BASE_RST = WAIT_W'(450);
  localparam logic [AVG_LOG2_W-1:0] AVG_LOG2_RST  = AVG_LOG2_W'(7);

  // Request to the serial multiplier.
  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } mul_req_t;

  // Request to the serial divider.
  typedef struct packed {
    logic                start;
    logic [WAIT_W-1:0]   dividend;
    logic [STREAK_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/mppt_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppt_acc (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 take_i,
  input  wire logic [mppt_pkg::SAMPLE_BITS-1:0]     volt_i,
  input  wire logic [mppt_pkg::SAMPLE_BITS-1:0]     amp_i,
  input  wire logic [mppt_pkg::AVG_LOG2_W-1:0]      avg_log2_i,
  output logic                                      done_o,
  output logic [mppt_pkg::OPND_W-1:0]               volt_avg_o,
  output logic [mppt_pkg::OPND_W-1:0]               amp_avg_o
);

  logic [mppt_pkg::SUM_W-1:0] volt_sum_q, volt_sum_d;
  logic [mppt_pkg::SUM_W-1:0] amp_sum_q, amp_sum_d;
  logic [mppt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [mppt_pkg::IDX_W-1:0] count;

  // Running sums including the sample on offer.
  always_comb begin
    volt_sum_d = volt_sum_q + mppt_pkg::SUM_W'(volt_i);
    amp_sum_d  = amp_sum_q + mppt_pkg::SUM_W'(amp_i);
    idx_d      = idx_q + mppt_pkg::IDX_W'(1);
    count      = mppt_pkg::IDX_W'(1) << avg_log2_i;
  end

  // The measurement closes once the count reaches or passes 2^k.
  assign done_o     = (idx_d >= count);
  assign volt_avg_o = mppt_pkg::OPND_W'(volt_sum_d >> avg_log2_i);
  assign amp_avg_o  = mppt_pkg::OPND_W'(amp_sum_d >> avg_log2_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_sum_q <= '0;
      amp_sum_q  <= '0;
      idx_q      <= '0;
    end else if (take_i) begin
      if (done_o) begin
        volt_sum_q <= '0;
        amp_sum_q  <= '0;
        idx_q      <= '0;
      end else begin
        volt_sum_q <= volt_sum_d;
        amp_sum_q  <= amp_sum_d;
        idx_q      <= idx_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mppt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppt_mul (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mppt_pkg::mul_req_t               req_i,
  output logic                                  done_o,
  output logic [mppt_pkg::PROD_W-1:0]           prod_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [mppt_pkg::MUL_CNT_W-1:0]      cnt_q;
  logic [mppt_pkg::OPND_W-1:0]         acc_q;
  logic [mppt_pkg::OPND_W-1:0]         plier_q;
  logic [mppt_pkg::OPND_W-1:0]         mcand_q;
  logic [mppt_pkg::OPND_W:0]           sum;

  // One multiplier bit per cycle: add the multiplicand, then shift right.
  always_comb begin
    sum = {1'b0, acc_q};
    if (plier_q[0]) begin
      sum = {1'b0, acc_q} + {1'b0, mcand_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= mppt_pkg::MUL_CNT_W'(mppt_pkg::OPND_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - mppt_pkg::MUL_CNT_W'(1);
        end
      end
    end
  end

  // Partial product in the upper half, multiplier bits shift out below.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q   <= '0;
      plier_q <= req_i.b;
      mcand_q <= req_i.a;
    end else if (busy_q) begin
      acc_q   <= sum[mppt_pkg::OPND_W:1];
      plier_q <= {sum[0], plier_q[mppt_pkg::OPND_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {acc_q, plier_q};

endmodule

`default_nettype wire

// ===== hdl/mppt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mppt_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mppt_pkg::div_req_t               req_i,
  output logic                                  done_o,
  output logic [mppt_pkg::WAIT_W-1:0]           quo_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [mppt_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [mppt_pkg::STREAK_W-1:0]       rem_q;
  logic [mppt_pkg::WAIT_W-1:0]         quo_q;
  logic [mppt_pkg::STREAK_W-1:0]       dvs_q;
  logic [mppt_pkg::STREAK_W:0]         shifted;
  logic [mppt_pkg::STREAK_W:0]         diff;
  logic                                fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[mppt_pkg::WAIT_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= mppt_pkg::DIV_CNT_W'(mppt_pkg::WAIT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - mppt_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  // The dividend shifts out of the top as quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[mppt_pkg::STREAK_W-1:0] : shifted[mppt_pkg::STREAK_W-1:0];
      quo_q <= {quo_q[mppt_pkg::WAIT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/mppt_perturb_observe_adaptive.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adaptive perturb-and-observe maximum power point tracker.
// The slave stream carries one voltage and one current converter sample per
// request. The block sums 2^k pairs (k from the average_log2 register), then
// multiplies the averaged sums into panel power and takes one duty step.
// Each closed measurement sends one request on the master stream with the new
// duty, the power, the wait time and the success streak; other samples send
// nothing. For a closing sample the result is computed by two passes of the
// bit-serial multiplier (power, then step times streak) and one pass of the
// bit-serial divider (wait time). s_axis_tready is low from the closing
// sample until the result is loaded into the output register, so no further
// sample is accepted over that run.
// The result sits in an output register; the next measurement can run while
// it waits, and it holds before the load until the receiver takes the
// earlier result.
// Reset clears sums, duty, direction and previous power, sets the streak to one
// and loads the register defaults. Registers sit on an APB port at byte address
// 4*i; the user must write them only while no measurement is running (unchecked).
module mppt_perturb_observe_adaptive (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream; tdata: volt_sample [9:0], amp_sample [19:10], zero fill.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  // Master stream; tdata: duty_out [7:0], power_out [27:8], wait_ms [43:28],
  // streak_out [51:44], zero fill.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] REG_DUTY_MAX  = 3'd0;
  localparam logic [2:0] REG_DUTY_MIN  = 3'd1;
  localparam logic [2:0] REG_DUTY_STEP = 3'd2;
  localparam logic [2:0] REG_WAIT_BASE = 3'd3;
  localparam logic [2:0] REG_AVG_LOG2  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PWR_GO,
    S_PWR,
    S_STEP_GO,
    S_STEP,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [mppt_pkg::DUTY_W-1:0]     duty_max_q;
  logic [mppt_pkg::DUTY_W-1:0]     duty_min_q;
  logic [mppt_pkg::DUTY_W-1:0]     duty_step_q;
  logic [mppt_pkg::WAIT_W-1:0]     wait_base_q;
  logic [mppt_pkg::AVG_LOG2_W-1:0] avg_log2_q;
  logic                            cfg_wr;

  // Tracker state and working registers.
  logic [mppt_pkg::POWER_W-1:0]  prev_power_q;
  logic [mppt_pkg::POWER_W-1:0]  power_q;
  logic [mppt_pkg::DUTY_W-1:0]   duty_now_q;
  logic                          going_up_q;
  logic [mppt_pkg::STREAK_W-1:0] streak_q;
  logic                          success_q;
  logic [mppt_pkg::WAIT_W-1:0]   wait_q;
  logic [mppt_pkg::OPND_W-1:0]   op_a_q;
  logic [mppt_pkg::OPND_W-1:0]   op_b_q;
  logic                          m_tvalid_q;
  logic [55:0]                   m_tdata_q;

  // Unit interfaces.
  logic                          take;
  logic                          acc_done;
  logic [mppt_pkg::OPND_W-1:0]   volt_avg;
  logic [mppt_pkg::OPND_W-1:0]   amp_avg;
  mppt_pkg::mul_req_t            mul_req;
  logic                          mul_done;
  logic [mppt_pkg::PROD_W-1:0]   mul_prod;
  mppt_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [mppt_pkg::WAIT_W-1:0]   div_quo;

  // Step logic.
  logic [mppt_pkg::POWER_W-1:0]        power_new;
  logic [mppt_pkg::STEP_W-1:0]         step;
  logic                                up;
  logic signed [mppt_pkg::VALUE_W-1:0] value;
  logic signed [mppt_pkg::VALUE_W-1:0] duty_ext;
  logic signed [mppt_pkg::VALUE_W-1:0] step_ext;
  logic signed [mppt_pkg::VALUE_W-1:0] max_ext;
  logic signed [mppt_pkg::VALUE_W-1:0] min_ext;
  logic [mppt_pkg::DUTY_W-1:0]         duty_new;
  logic [mppt_pkg::STREAK_W-1:0]       streak_new;

  // Configuration port: writes complete in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_max_q  <= mppt_pkg::DUTY_MAX_RST;
      duty_min_q  <= mppt_pkg::DUTY_MIN_RST;
      duty_step_q <= mppt_pkg::DUTY_STEP_RST;
      wait_base_q <= mppt_pkg::WAIT_BASE_RST;
      avg_log2_q  <= mppt_pkg::AVG_LOG2_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DUTY_MAX:  duty_max_q  <= pwdata[mppt_pkg::DUTY_W-1:0];
        REG_DUTY_MIN:  duty_min_q  <= pwdata[mppt_pkg::DUTY_W-1:0];
        REG_DUTY_STEP: duty_step_q <= pwdata[mppt_pkg::DUTY_W-1:0];
        REG_WAIT_BASE: wait_base_q <= pwdata[mppt_pkg::WAIT_W-1:0];
        REG_AVG_LOG2:  avg_log2_q  <= pwdata[mppt_pkg::AVG_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DUTY_MAX:  prdata = 32'(duty_max_q);
      REG_DUTY_MIN:  prdata = 32'(duty_min_q);
      REG_DUTY_STEP: prdata = 32'(duty_step_q);
      REG_WAIT_BASE: prdata = 32'(wait_base_q);
      REG_AVG_LOG2:  prdata = 32'(avg_log2_q);
      default:       prdata = '0;
    endcase
  end

  // Sample accumulation.
  assign s_axis_tready = (state_q == S_IDLE);
  assign take          = s_axis_tvalid & s_axis_tready;

  mppt_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .volt_i     (s_axis_tdata[9:0]),
    .amp_i      (s_axis_tdata[19:10]),
    .avg_log2_i (avg_log2_q),
    .done_o     (acc_done),
    .volt_avg_o (volt_avg),
    .amp_avg_o  (amp_avg)
  );

  // Shared serial multiplier for the power and for the scaled step.
  assign mul_req.start = (state_q == S_PWR_GO) || (state_q == S_STEP_GO);
  assign mul_req.a     = op_a_q;
  assign mul_req.b     = op_b_q;

  mppt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Serial divider for the wait time.
  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = wait_base_q;
  assign div_req.divisor  = streak_q;

  mppt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Perturbation step: move the duty and clamp it, testing the upper bound first.
  always_comb begin
    power_new = mul_prod[mppt_pkg::POWER_W-1:0];
    step      = mul_prod[mppt_pkg::STEP_W-1:0];
    up        = success_q ? going_up_q : ~going_up_q;
    duty_ext  = $signed(mppt_pkg::VALUE_W'(duty_now_q));
    step_ext  = $signed(mppt_pkg::VALUE_W'(step));
    max_ext   = $signed(mppt_pkg::VALUE_W'(duty_max_q));
    min_ext   = $signed(mppt_pkg::VALUE_W'(duty_min_q));
    value     = up ? (duty_ext + step_ext) : (duty_ext - step_ext);
    priority if (value >= max_ext) begin
      duty_new = duty_max_q;
    end else if (value <= min_ext) begin
      duty_new = duty_min_q;
    end else begin
      duty_new = value[mppt_pkg::DUTY_W-1:0];
    end
    priority if (!success_q) begin
      streak_new = mppt_pkg::STREAK_W'(1);
    end else if (streak_q >= mppt_pkg::STREAK_W'(mppt_pkg::STREAK_LIMIT)) begin
      streak_new = mppt_pkg::STREAK_W'(mppt_pkg::STREAK_LIMIT);
    end else begin
      streak_new = streak_q + mppt_pkg::STREAK_W'(1);
    end
  end

  // Measurement sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_power_q <= '0;
      duty_now_q   <= '0;
      going_up_q   <= 1'b0;
      streak_q     <= mppt_pkg::STREAK_W'(1);
      success_q    <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take && acc_done) begin
            state_q <= S_PWR_GO;
          end
        end
        S_PWR_GO: begin
          state_q <= S_PWR;
        end
        S_PWR: begin
          if (mul_done) begin
            success_q    <= (power_new > prev_power_q);
            prev_power_q <= power_new;
            state_q      <= S_STEP_GO;
          end
        end
        S_STEP_GO: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (mul_done) begin
            duty_now_q <= duty_new;
            going_up_q <= up;
            streak_q   <= streak_new;
            state_q    <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // The output register loads a new result, or empties once it is taken.
      priority if ((state_q == S_OUT) && (!m_tvalid_q || m_axis_tready)) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take && acc_done) begin
      op_a_q <= volt_avg;
      op_b_q <= amp_avg;
    end
    if ((state_q == S_PWR) && mul_done) begin
      power_q <= power_new;
      op_a_q  <= mppt_pkg::OPND_W'(duty_step_q);
      op_b_q  <= mppt_pkg::OPND_W'(streak_q);
    end
    if ((state_q == S_DIV) && div_done) begin
      wait_q <= (streak_q > mppt_pkg::STREAK_W'(mppt_pkg::STREAK_FAST)) ? div_quo : wait_base_q;
    end
    if ((state_q == S_OUT) && (!m_tvalid_q || m_axis_tready)) begin
      m_tdata_q <= {4'b0, streak_q, wait_q, power_q, duty_now_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire
